FILE: rtl/t3nps_pkg.sv
// Shared types and constants for the nearest-three grid point selector.
// Used by the channel interfaces and by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package t3nps_pkg;

  // Packed point layout: three signed coordinates of FIELD_BITS each
  localparam int FIELD_BITS = 10;
  localparam int POS_BITS   = 30;
  localparam int DIST_BITS  = 22;
  localparam int SLOTS      = 3;

  // Arithmetic widths of the distance datapath
  localparam int DIFF_BITS  = FIELD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic signed [FIELD_BITS-1:0] coord_t;
  typedef logic [POS_BITS-1:0]          pos_t;
  typedef logic [DIST_BITS-1:0]         dist_t;

  localparam dist_t DIST_MAX = {DIST_BITS{1'b1}};

  // Classified candidate handed from front to back
  typedef struct packed {
    pos_t  pos;
    dist_t sq_dist;
    logic  first;
    logic  last;
  } item_t;

  // One slot of the nearest list
  typedef struct packed {
    pos_t  pos;
    dist_t sq_dist;
  } entry_t;

  typedef entry_t [SLOTS-1:0] list_t;

  localparam entry_t ENTRY_EMPTY = '{pos: '0, sq_dist: DIST_MAX};

endpackage

`default_nettype wire

FILE: rtl/t3nps_if.sv
// Valid/ready channel interfaces for candidate input and result output.
// Depends on t3nps_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface t3nps_in_if;
  import t3nps_pkg::*;

  logic   valid;
  logic   ready;
  pos_t   candidate_hash;
  coord_t ref_x;
  coord_t ref_y;
  coord_t ref_z;
  logic   first;
  logic   last;

  modport source (
    output valid, candidate_hash, ref_x, ref_y, ref_z, first, last,
    input  ready
  );

  modport sink (
    input  valid, candidate_hash, ref_x, ref_y, ref_z, first, last,
    output ready
  );
endinterface

interface t3nps_out_if;
  import t3nps_pkg::*;

  logic  valid;
  logic  ready;
  pos_t  near_pos;
  dist_t near_dist;
  pos_t  mid_pos;
  dist_t mid_dist;
  pos_t  far_pos;
  dist_t far_dist;

  modport source (
    output valid, near_pos, near_dist, mid_pos, mid_dist, far_pos, far_dist,
    input  ready
  );

  modport sink (
    input  valid, near_pos, near_dist, mid_pos, mid_dist, far_pos, far_dist,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/top3_nearest_grid_point_select_top.sv
// Top level of the nearest-three grid point selector.
// Depends on t3nps_pkg, t3nps_if, t3nps_front, t3nps_queue and t3nps_back.
//
//   channel | dir | handshake             | payload
//   in_if   | in  | in_if.valid/ready     | candidate_hash, ref_x/y/z, first, last
//   out_if  | out | out_if.valid/ready    | near/mid/far pos and dist
//
// One candidate per cycle sustained while the output is not stalled on a last
// item. The front, the queue and the back each register the item once, in that
// order, before out_if.valid rises for a last candidate. The list update in the
// back is a combinational compare-insert registered per item, which sets the
// one-item-per-cycle rate. Reset (rst_n, synchronous) clears the list to the
// sentinel and empties the queue. A stalled output holds only the back on a
// last item; the queue keeps absorbing candidates until it fills.
`timescale 1ns / 1ps
`default_nettype none

module top3_nearest_grid_point_select_top #(
  parameter int QUEUE_DEPTH = t3nps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  t3nps_in_if.sink     in_if,
  t3nps_out_if.source  out_if
);
  import t3nps_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  q_valid, q_ready;
  item_t q_item;
  list_t out_list;

  t3nps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_hash    (in_if.candidate_hash),
    .in_ref_x   (in_if.ref_x),
    .in_ref_y   (in_if.ref_y),
    .in_ref_z   (in_if.ref_z),
    .in_first   (in_if.first),
    .in_last    (in_if.last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  t3nps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  t3nps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_list  (out_list)
  );

  // Map list slots onto the result fields
  assign out_if.near_pos  = out_list[0].pos;
  assign out_if.near_dist = out_list[0].sq_dist;
  assign out_if.mid_pos   = out_list[1].pos;
  assign out_if.mid_dist  = out_list[1].sq_dist;
  assign out_if.far_pos   = out_list[2].pos;
  assign out_if.far_dist  = out_list[2].sq_dist;

endmodule

`default_nettype wire

FILE: rtl/t3nps_front.sv
// Front stage: accepts candidates, unpacks them and forms the squared distance.
// Depends on t3nps_pkg; feeds t3nps_queue.
`timescale 1ns / 1ps
`default_nettype none

module t3nps_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  t3nps_pkg::pos_t         in_hash,
  input  t3nps_pkg::coord_t       in_ref_x,
  input  t3nps_pkg::coord_t       in_ref_y,
  input  t3nps_pkg::coord_t       in_ref_z,
  input  wire                     in_first,
  input  wire                     in_last,
  output logic                    push_valid,
  input  wire                     push_ready,
  output t3nps_pkg::item_t        push_item
);
  import t3nps_pkg::*;

  logic                        fr_valid_r;
  logic                        fr_valid_nxt;
  item_t                       fr_item_r;
  coord_t                      cx, cy, cz;
  logic signed [DIFF_BITS-1:0] dx, dy, dz;
  logic signed [SQ_BITS-1:0]   sqx, sqy, sqz;
  logic [SUM_BITS-1:0]         sum;
  dist_t                       sq_dist;

  // Unpack candidate coordinates
  assign cx = coord_t'(in_hash[FIELD_BITS-1:0]);
  assign cy = coord_t'(in_hash[2*FIELD_BITS-1:FIELD_BITS]);
  assign cz = coord_t'(in_hash[3*FIELD_BITS-1:2*FIELD_BITS]);

  // Differences to the reference point, one bit wider to avoid overflow
  assign dx = {cx[FIELD_BITS-1], cx} - {in_ref_x[FIELD_BITS-1], in_ref_x};
  assign dy = {cy[FIELD_BITS-1], cy} - {in_ref_y[FIELD_BITS-1], in_ref_y};
  assign dz = {cz[FIELD_BITS-1], cz} - {in_ref_z[FIELD_BITS-1], in_ref_z};

  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sqz = dz * dz;

  // Sum of squares, saturated to the sentinel
  assign sum = SUM_BITS'(unsigned'(sqx)) + SUM_BITS'(unsigned'(sqy))
             + SUM_BITS'(unsigned'(sqz));
  assign sq_dist = (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];

  // Take a new candidate whenever the stage is empty or drains this cycle
  assign in_ready     = !fr_valid_r || push_ready;
  assign fr_valid_nxt = (in_valid && in_ready) || (fr_valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  // Hold the payload until it transfers into the queue
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item_r.pos     <= in_hash;
      fr_item_r.sq_dist <= sq_dist;
      fr_item_r.first   <= in_first;
      fr_item_r.last    <= in_last;
    end
  end

  assign push_valid = fr_valid_r;
  assign push_item  = fr_item_r;

endmodule

`default_nettype wire

FILE: rtl/t3nps_queue.sv
// Short queue that decouples the distance front from the list back.
// Depends on t3nps_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module t3nps_queue #(
  parameter int DEPTH = t3nps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_valid,
  output logic              wr_ready,
  input  t3nps_pkg::item_t  wr_item,
  output logic              rd_valid,
  input  wire               rd_ready,
  output t3nps_pkg::item_t  rd_item
);
  import t3nps_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

  item_t                mem_r [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 push, pop;

  assign wr_ready = (cnt_r != CNT_BITS'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry on each transfer in
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  // Fill level never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(DEPTH))
    else $error("queue count exceeds depth");

  // A lone push grows the fill level by exactly one
  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a push");

  // An empty queue has its pointers together
  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

FILE: rtl/t3nps_back.sv
// Back stage: keeps the sorted nearest-three list and registers results.
// Depends on t3nps_pkg; drained from t3nps_queue.
`timescale 1ns / 1ps
`default_nettype none

module t3nps_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  output logic               q_ready,
  input  t3nps_pkg::item_t   q_item,
  output logic               out_valid,
  input  wire                out_ready,
  output t3nps_pkg::list_t   out_list
);
  import t3nps_pkg::*;

  list_t list_r, list_nxt;
  list_t base;
  list_t out_list_r;
  logic  out_valid_r, out_valid_nxt;
  logic  pop;
  entry_t cand;

  // Stall only when a result is due and the output register is still full
  assign q_ready = !q_item.last || !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  assign cand.pos     = q_item.pos;
  assign cand.sq_dist = q_item.sq_dist;

  // Clear on first, then insert; equal distance goes ahead of the stored one
  always_comb begin
    base = q_item.first ? {SLOTS{ENTRY_EMPTY}} : list_r;
    list_nxt = base;
    priority if (base[0].sq_dist >= cand.sq_dist) begin
      list_nxt[2] = base[1];
      list_nxt[1] = base[0];
      list_nxt[0] = cand;
    end else if (base[1].sq_dist >= cand.sq_dist) begin
      list_nxt[2] = base[1];
      list_nxt[1] = cand;
    end else if (base[2].sq_dist >= cand.sq_dist) begin
      list_nxt[2] = cand;
    end else begin
      list_nxt = base;
    end
  end

  assign out_valid_nxt = (pop && q_item.last) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_r      <= {SLOTS{ENTRY_EMPTY}};
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        list_r <= list_nxt;
      end
    end
  end

  // Capture the list for a result on the last candidate
  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      out_list_r <= list_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_list  = out_list_r;

  // The kept list stays sorted by distance
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (list_r[0].sq_dist <= list_r[1].sq_dist) && (list_r[1].sq_dist <= list_r[2].sq_dist))
    else $error("nearest list out of order");

  // A last candidate always raises a result
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.last) |=> out_valid_r)
    else $error("no result after last candidate");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(pop && q_item.last))
    else $error("result overwritten while pending");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the nearest-three grid point selector.
// Needs t3nps_pkg, the t3nps_in_if/t3nps_out_if channels and the block's top level.
`timescale 1ns / 1ps

module tb;
  import t3nps_pkg::*;

  localparam int RANDOM_ITEMS    = 580;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    pos_t   hash;
    coord_t rx;
    coord_t ry;
    coord_t rz;
    logic   first;
    logic   last;
  } cand_t;

  typedef struct packed {
    pos_t  near_pos;
    dist_t near_dist;
    pos_t  mid_pos;
    dist_t mid_dist;
    pos_t  far_pos;
    dist_t far_dist;
  } list_rec_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

  // Tracks the nearest-three list and the lists still owed by the block
  class nearest3_board;
    dist_t     keep_dist [SLOTS];
    pos_t      keep_pos  [SLOTS];
    list_rec_t pending_lists [$];
    int        failures;
    int        reported;

    function new();
      clear_list();
      failures = 0;
      reported = 0;
    endfunction

    function void clear_list();
      for (int i = 0; i < SLOTS; i++) begin
        keep_dist[i] = DIST_MAX;
        keep_pos[i]  = '0;
      end
    endfunction

    // Squared distance from the unpacked candidate to the reference, saturated
    function dist_t grid_dist(cand_t c);
      coord_t     f;
      longint     cx, cy, cz, dx, dy, dz, s;
      f  = c.hash[FIELD_BITS-1:0];
      cx = f;
      f  = c.hash[2*FIELD_BITS-1:FIELD_BITS];
      cy = f;
      f  = c.hash[3*FIELD_BITS-1:2*FIELD_BITS];
      cz = f;
      dx = cx - longint'(c.rx);
      dy = cy - longint'(c.ry);
      dz = cz - longint'(c.rz);
      s  = dx * dx + dy * dy + dz * dz;
      if (s > longint'(DIST_MAX)) s = longint'(DIST_MAX);
      return dist_t'(s);
    endfunction

    function void note_candidate(cand_t c);
      dist_t     d;
      int        slot;
      list_rec_t rec;
      d = grid_dist(c);
      if (c.first) clear_list();
      // Pick the first slot not nearer than the candidate; ties go ahead
      slot = SLOTS;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (keep_dist[i] >= d) slot = i;
      if (slot < SLOTS) begin
        for (int j = SLOTS - 1; j > slot; j--) begin
          keep_dist[j] = keep_dist[j-1];
          keep_pos[j]  = keep_pos[j-1];
        end
        keep_dist[slot] = d;
        keep_pos[slot]  = c.hash;
      end
      if (c.last) begin
        rec.near_pos  = keep_pos[0];
        rec.near_dist = keep_dist[0];
        rec.mid_pos   = keep_pos[1];
        rec.mid_dist  = keep_dist[1];
        rec.far_pos   = keep_pos[2];
        rec.far_dist  = keep_dist[2];
        pending_lists.push_back(rec);
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (reported < REPORT_LIMIT) begin
        reported++;
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got)
        note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
    endfunction

    function void check_list(list_rec_t got);
      list_rec_t want;
      if (pending_lists.size() == 0) begin
        note_failure("result transfer with no list pending");
        return;
      end
      want = pending_lists.pop_front();
      compare_field("near_pos",  want.near_pos,  got.near_pos);
      compare_field("near_dist", want.near_dist, got.near_dist);
      compare_field("mid_pos",   want.mid_pos,   got.mid_pos);
      compare_field("mid_dist",  want.mid_dist,  got.mid_dist);
      compare_field("far_pos",   want.far_pos,   got.far_pos);
      compare_field("far_dist",  want.far_dist,  got.far_dist);
    endfunction

    function void close_out();
      if (pending_lists.size() != 0)
        note_failure($sformatf("%0d lists never arrived", pending_lists.size()));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  t3nps_in_if  in_ch ();
  t3nps_out_if out_ch ();

  top3_nearest_grid_point_select_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  nearest3_board board = new();
  cand_t         stim_q [$];
  bit            hold_req;
  bit            hold_done;
  int            idle_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pos_t pack_pt(int x, int y, int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  task automatic add_item(pos_t h, int rx, int ry, int rz, bit f, bit l);
    cand_t c;
    c.hash  = h;
    c.rx    = coord_t'(rx);
    c.ry    = coord_t'(ry);
    c.rz    = coord_t'(rz);
    c.first = f;
    c.last  = l;
    stim_q.push_back(c);
  endtask

  // Offer one candidate and hold it until the transfer
  task automatic offer(cand_t c);
    in_ch.valid          <= 1'b1;
    in_ch.candidate_hash <= c.hash;
    in_ch.ref_x          <= c.rx;
    in_ch.ref_y          <= c.ry;
    in_ch.ref_z          <= c.rz;
    in_ch.first          <= c.first;
    in_ch.last           <= c.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Sample both channels at the edge; watch for a hang
  always @(posedge clk) begin
    cand_t     c;
    list_rec_t r;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        c.hash  = in_ch.candidate_hash;
        c.rx    = in_ch.ref_x;
        c.ry    = in_ch.ref_y;
        c.rz    = in_ch.ref_z;
        c.first = in_ch.first;
        c.last  = in_ch.last;
        board.note_candidate(c);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        r.near_pos  = out_ch.near_pos;
        r.near_dist = out_ch.near_dist;
        r.mid_pos   = out_ch.mid_pos;
        r.mid_dist  = out_ch.mid_dist;
        r.far_pos   = out_ch.far_pos;
        r.far_dist  = out_ch.far_dist;
        board.check_list(r);
        moved = 1'b1;
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: stall on changing patterns, plus one long hold-off on request
  initial begin
    rx_mode_t   mode;
    int         seg_left;
    logic [1:0] pulse_phase;
    logic       r;
    mode        = RX_OPEN;
    seg_left    = 0;
    pulse_phase = '0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(1, 60);
        end
        seg_left--;
        pulse_phase++;
        case (mode)
          RX_OPEN:   r = 1'b1;
          RX_COIN:   r = 1'($urandom_range(0, 1));
          RX_SPARSE: r = ($urandom_range(0, 3) == 0);
          default:   r = pulse_phase[1];
        endcase
        out_ch.ready <= r;
        @(posedge clk);
      end
    end
  end

  // Stimulus, sender and end of run
  initial begin
    int   random_items, glen, k, pick, burst_left, pressure_at;
    int   gx, gy, gz;
    bit   keep_first, keep_last;
    pos_t h, prev_h;

    hold_req    = 1'b0;
    hold_done   = 1'b0;
    idle_cycles = 0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.candidate_hash <= '0;
    in_ch.ref_x          <= '0;
    in_ch.ref_y          <= '0;
    in_ch.ref_z          <= '0;
    in_ch.first          <= 1'b0;
    in_ch.last           <= 1'b0;

    // Directed: list from reset values without a first flag
    add_item(pack_pt(3, 4, 0), 0, 0, 0, 1'b0, 1'b1);
    // Single candidate at zero distance: two empty slots remain
    add_item(pack_pt(0, 0, 0), 0, 0, 0, 1'b1, 1'b1);
    // Extreme coordinates, largest distance, tie goes ahead
    add_item(pack_pt(-512, -512, -512), 511, 511, 511, 1'b1, 1'b0);
    add_item(pack_pt(511, 511, 511), -512, -512, -512, 1'b0, 1'b1);
    // All-ones word, equal distances, and a candidate farther than the whole list
    add_item(30'h3FFFFFFF, -1, -1, -1, 1'b1, 1'b0);
    add_item(pack_pt(1, 0, 0), 0, 0, 0, 1'b0, 1'b0);
    add_item(pack_pt(0, -1, 0), 0, 0, 0, 1'b0, 1'b0);
    add_item(pack_pt(0, 0, 2), 0, 0, 0, 1'b0, 1'b1);
    // Insert in the middle, and a tie with the third slot
    add_item(pack_pt(5, 0, 0), 0, 0, 0, 1'b1, 1'b0);
    add_item(pack_pt(0, 3, 0), 0, 0, 0, 1'b0, 1'b0);
    add_item(pack_pt(0, 0, 4), 0, 0, 0, 1'b0, 1'b0);
    add_item(pack_pt(2, 2, 2), 0, 0, 0, 1'b0, 1'b1);
    add_item(pack_pt(0, 4, 0), 0, 0, 0, 1'b0, 1'b1);
    // Mixed signs and alternating bit patterns
    add_item(pack_pt(-300, 200, -100), 100, -200, 300, 1'b1, 1'b1);
    add_item(30'h2AAAAAAA, -512, 511, 0, 1'b1, 1'b0);
    add_item(30'h15555555, 511, -512, -1, 1'b0, 1'b0);
    add_item(pack_pt(511, -512, 511), 511, -512, 511, 1'b0, 1'b1);
    add_item(pack_pt(-512, 511, -512), 0, 0, 0, 1'b1, 1'b1);

    pressure_at = stim_q.size() + 250;

    // Random: mostly framed groups, some broken framing and loose noise
    random_items = 0;
    prev_h       = '0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        add_item(pos_t'($urandom()), $urandom(), $urandom(), $urandom(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        random_items++;
      end else begin
        glen       = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                 : $urandom_range(1, 6);
        gx         = $urandom_range(0, 1023) - 512;
        gy         = $urandom_range(0, 1023) - 512;
        gz         = $urandom_range(0, 1023) - 512;
        keep_first = ($urandom_range(0, 9) != 0);
        keep_last  = ($urandom_range(0, 9) != 0);
        for (k = 0; k < glen; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            gx = $urandom_range(0, 1023) - 512;
            gy = $urandom_range(0, 1023) - 512;
            gz = $urandom_range(0, 1023) - 512;
          end
          pick = $urandom_range(0, 9);
          if (pick < 4)
            h = pos_t'($urandom());
          else if (pick < 8)
            h = pack_pt(gx + $urandom_range(0, 16) - 8, gy + $urandom_range(0, 16) - 8,
                        gz + $urandom_range(0, 16) - 8);
          else
            h = (k > 0) ? prev_h : pos_t'($urandom());
          add_item(h, gx, gy, gz, (k == 0) && keep_first, (k == glen - 1) && keep_last);
          prev_h = h;
          random_items++;
        end
      end
    end

    // Reset
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Send in bursts with gaps; once, keep offering through the long hold-off
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < stim_q.size(); i++) begin
      offer(stim_q[i]);
      burst_left--;
      if (i == pressure_at) begin
        hold_req   = 1'b1;
        burst_left = 60;
      end
      if (burst_left <= 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain; step one edge so the final transfer is already noted
    @(posedge clk);
    while (board.pending_lists.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();
    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
